// File: rtl/tslf_pkg.sv
// Shared types and constants for the text stream line filter.
`default_nettype none

package tslf_pkg;

    // Columns taken by the line number
    localparam int NUM_DIGITS = 6;
    // Digits that can be nonzero: the count stops at 999999 or at all nines
    localparam int NUM_LIM = (NUM_DIGITS < 6) ? NUM_DIGITS : 6;

    // Output slots in order: number digits, tab, M, -, ^, $, character
    localparam int SLOTS       = NUM_DIGITS + 6;
    localparam int SLOT_TAB    = NUM_DIGITS;
    localparam int SLOT_M      = NUM_DIGITS + 1;
    localparam int SLOT_DASH   = NUM_DIGITS + 2;
    localparam int SLOT_CARET  = NUM_DIGITS + 3;
    localparam int SLOT_DOLLAR = NUM_DIGITS + 4;
    localparam int SLOT_CHAR   = NUM_DIGITS + 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONPRINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENDS     = 3'd4;

    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    // Characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_FLIP = 8'h40;
    localparam logic [3:0] DIGIT_HI  = 4'h3;
    localparam logic [3:0] BCD_NINE  = 4'd9;

    typedef logic [NUM_LIM-1:0][3:0] bcd_t;
    localparam bcd_t BCD_ONE = bcd_t'(1);

    typedef struct packed {
        logic       squeeze;
        logic [1:0] num_mode;
        logic       show_tabs;
        logic       show_np;
        logic       show_ends;
    } cfg_t;

    // One classified item waiting for expansion
    typedef struct packed {
        logic       numbered;
        logic       meta;
        logic       caret;
        logic       dollar;
        logic [7:0] chr;
        bcd_t       digits;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/tslf_front.sv
// Front end: accepts input bytes, tracks line state and classifies each item.
`default_nettype none

module tslf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tslf_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output tslf_pkg::job_t     job
);
    import tslf_pkg::*;

    logic [7:0] prev_reg, prev_next;
    logic [1:0] blank_reg, blank_next;
    bcd_t       num_reg, num_next;

    logic       accept;
    logic       at_start;
    logic       sq_hit;
    logic       drop;
    logic       numbered;
    logic       num_sat;
    bcd_t       num_inc;
    logic       carry;
    logic       tab_caret;
    logic [7:0] c1, c2, c3;
    logic       meta;
    logic       ctrl;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign at_start = (prev_reg == CH_NL);
    assign sq_hit   = cfg.squeeze && (in_byte == CH_NL) && at_start;
    // a repeated blank line is squeezed once one blank line has passed
    assign drop     = sq_hit && (blank_reg != 2'd0);
    assign numbered = at_start && ((cfg.num_mode == MODE_ALL) ||
                      ((cfg.num_mode == MODE_NONBLANK) && (in_byte != CH_NL)));

    // BCD line counter, holds at all nines
    always_comb
    begin
        num_sat = 1'b1;
        carry   = 1'b1;
        num_inc = num_reg;
        for (int i = 0; i < NUM_LIM; i++)
        begin
            if (num_reg[i] != BCD_NINE)
            begin
                num_sat = 1'b0;
            end
            if (carry)
            begin
                if (num_reg[i] == BCD_NINE)
                begin
                    num_inc[i] = 4'd0;
                end
                else
                begin
                    num_inc[i] = num_reg[i] + 4'd1;
                    carry      = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        tab_caret = cfg.show_tabs && (in_byte == CH_TAB);
        c1        = tab_caret ? CH_I : in_byte;
        meta      = 1'b0;
        ctrl      = 1'b0;
        c2        = c1;
        c3        = c1;
        if (cfg.show_np && (c1 != CH_TAB) && (c1 != CH_NL))
        begin
            meta = c1[7];
            c2   = {1'b0, c1[6:0]};
            ctrl = (c2 < 8'h20) || (c2 == CH_DEL);
            c3   = ctrl ? (c2 ^ CTRL_FLIP) : c2;
        end
    end

    assign job.numbered = numbered;
    assign job.meta     = meta;
    assign job.caret    = tab_caret || ctrl;
    assign job.dollar   = cfg.show_ends && (c3 == CH_NL);
    assign job.chr      = c3;
    assign job.digits   = num_reg;
    assign q_push       = accept && !drop;

    always_comb
    begin
        prev_next  = prev_reg;
        blank_next = blank_reg;
        num_next   = num_reg;
        if (accept)
        begin
            if (sq_hit)
            begin
                blank_next = (blank_reg == 2'd2) ? 2'd2 : blank_reg + 2'd1;
            end
            else
            begin
                blank_next = 2'd0;
            end
            if (!drop)
            begin
                prev_next = c3;
                if (numbered && !num_sat)
                begin
                    num_next = num_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= CH_NL;
            blank_reg <= 2'd0;
            num_reg   <= BCD_ONE;
        end
        else
        begin
            prev_reg  <= prev_next;
            blank_reg <= blank_next;
            num_reg   <= num_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslf_queue.sv
// Short queue of classified items between front and back end.
`default_nettype none

module tslf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tslf_pkg::job_t push_job,
    input  wire logic          pop,
    output tslf_pkg::job_t     head,
    output logic               full,
    output logic               empty
);
    import tslf_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslf_back.sv
// Back end: expands the queue head into output bytes, one per cycle while out_ready is high.
`default_nettype none

module tslf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tslf_pkg::job_t head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);
    import tslf_pkg::*;

    logic [SLOTS-1:0] done_reg, done_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic [SLOTS-1:0] en;
    logic [SLOTS-1:0] remain;
    logic [SLOTS-1:0] sel_hot;
    logic [7:0]       slot_chr [SLOTS];
    logic [NUM_LIM:0] any_hi;
    logic [7:0]       sel_chr;
    logic             is_last;
    logic             advance;
    logic             load;

    always_comb
    begin
        en              = '0;
        en[SLOT_TAB:0]  = {(SLOT_TAB+1){head.numbered}};
        en[SLOT_M]      = head.meta;
        en[SLOT_DASH]   = head.meta;
        en[SLOT_CARET]  = head.caret;
        en[SLOT_DOLLAR] = head.dollar;
        en[SLOT_CHAR]   = 1'b1;
    end

    // digit p is shown when it or any higher digit is nonzero, or it is the units
    always_comb
    begin
        any_hi[NUM_LIM] = 1'b0;
        for (int p = NUM_LIM - 1; p >= 0; p--)
        begin
            any_hi[p] = any_hi[p+1] || (head.digits[p] != 4'd0);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            slot_chr[j] = CH_SPACE;
            if ((NUM_DIGITS - 1 - j) < NUM_LIM)
            begin
                if ((j == NUM_DIGITS - 1) || any_hi[NUM_DIGITS - 1 - j])
                begin
                    slot_chr[j] = {DIGIT_HI, head.digits[NUM_DIGITS - 1 - j]};
                end
            end
        end
        slot_chr[SLOT_TAB]    = CH_TAB;
        slot_chr[SLOT_M]      = CH_M;
        slot_chr[SLOT_DASH]   = CH_DASH;
        slot_chr[SLOT_CARET]  = CH_CARET;
        slot_chr[SLOT_DOLLAR] = CH_DOLLAR;
        slot_chr[SLOT_CHAR]   = head.chr;
    end

    assign remain  = en & ~done_reg;
    assign sel_hot = remain & (~remain + 1'b1);
    assign is_last = ((remain & ~sel_hot) == '0);

    always_comb
    begin
        sel_chr = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel_chr = sel_chr | (sel_hot[i] ? slot_chr[i] : 8'h00);
        end
    end

    assign advance = !valid_reg || out_ready;
    assign load    = advance && !q_empty;
    assign q_pop   = load && is_last;

    always_comb
    begin
        done_next  = done_reg;
        valid_next = advance ? !q_empty : valid_reg;
        if (load)
        begin
            done_next = is_last ? '0 : (done_reg | sel_hot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_chr;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// File: rtl/text_stream_line_filter.sv
// An accepted item is written into the queue; the back end then registers its output bytes.
// Throughput: one output byte per cycle while out_ready is high; an item expands to 1 to
// NUM_DIGITS+5 bytes, and input is taken every cycle while the 4-entry queue has room.
// Squeezed blank lines are accepted but produce no output.
// Reset: options clear, line number 1, previous byte newline, blank count 0, queue empty.
`default_nettype none

module text_stream_line_filter (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tslf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     in_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_byte,
    output logic                                last_of_run
);
    import tslf_pkg::*;

    cfg_t cfg_reg;
    job_t push_job;
    job_t head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SQUEEZE:  cfg_reg.squeeze   <= cfg_data[0];
                REG_NUM_MODE: cfg_reg.num_mode  <= cfg_data[1:0];
                REG_TABS:     cfg_reg.show_tabs <= cfg_data[0];
                REG_NONPRINT: cfg_reg.show_np   <= cfg_data[0];
                REG_ENDS:     cfg_reg.show_ends <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    tslf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .job      (push_job)
    );

    tslf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tslf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");

    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_empty))
        else $error("output appeared with no queued item");

endmodule

`default_nettype wire

// File: sim/tb_text_stream_line_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text stream line filter with its option registers.
module tb_text_stream_line_filter;
    import tslf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int NUM_CAP       = (NUM_DIGITS >= 6) ? 999999 : (10 ** NUM_DIGITS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     val;
        logic [7:0]                chr;
        logic                      has_gold;
        logic [2:0]                gold_len;
        logic [31:0]               gold;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } out_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  last_of_run;

    // Typed-in expectation that travels with the byte on the input port
    logic                  row_has_gold = 1'b0;
    logic [2:0]            row_gold_len = '0;
    logic [31:0]           row_gold = '0;

    // Predictor state and option copy
    cfg_t                  opts = '0;
    int                    line_num = 1;
    logic [7:0]            last_chr = CH_NL;
    logic [1:0]            blank_cnt = '0;

    logic [7:0]            run_chars[$];
    out_char_t             pending_chars[$];
    stim_row_t             stim_rows[$];

    int                    in_idle_pct = 28;
    int                    out_idle_pct = 86;
    int                    err_count = 0;
    int                    items_sent = 0;
    int                    squeezed = 0;
    int                    beats_checked = 0;

    text_stream_line_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_of_run(last_of_run)
    );

    always #(CLK_HALF) clk = ~clk;

    // Work out the expansion of one raw byte and advance the line state
    function automatic void expand_byte(input logic [7:0] raw);
        logic [7:0] c;
        logic       at_start;
        logic       numbered;
        int         v;
        logic [7:0] digits [NUM_DIGITS];
        c = raw;
        run_chars.delete();
        at_start = (last_chr == CH_NL);
        if (opts.squeeze && c == CH_NL && at_start)
        begin
            if (blank_cnt < 2)
                blank_cnt++;
            if (blank_cnt > 1)
                return;
        end
        else
            blank_cnt = '0;

        numbered = at_start && (opts.num_mode == MODE_ALL ||
                   (opts.num_mode == MODE_NONBLANK && c != CH_NL));
        if (numbered)
        begin
            v = (line_num > NUM_CAP) ? NUM_CAP : line_num;
            for (int k = NUM_DIGITS - 1; k >= 0; k--)
            begin
                if (k == NUM_DIGITS - 1 || v != 0)
                begin
                    digits[k] = 8'(CH_ZERO + v % 10);
                    v = v / 10;
                end
                else
                    digits[k] = CH_SPACE;
            end
            foreach (digits[k])
                run_chars.push_back(digits[k]);
            run_chars.push_back(CH_TAB);
            line_num = (line_num < NUM_CAP) ? line_num + 1 : NUM_CAP;
        end

        if (opts.show_tabs && c == CH_TAB)
        begin
            run_chars.push_back(CH_CARET);
            c = CH_I;
        end

        if (opts.show_np && c != CH_TAB && c != CH_NL)
        begin
            if (c[7])
            begin
                c[7] = 1'b0;
                run_chars.push_back(CH_M);
                run_chars.push_back(CH_DASH);
            end
            if (c < CH_SPACE || c == CH_DEL)
            begin
                c = c ^ CTRL_FLIP;
                run_chars.push_back(CH_CARET);
            end
        end

        if (opts.show_ends && c == CH_NL)
            run_chars.push_back(CH_DOLLAR);

        last_chr = c;
        run_chars.push_back(c);
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        return '{ROW_REG, idx, val, 8'h00, 1'b0, 3'd0, 32'd0};
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] chr);
        return '{ROW_ITEM, '0, '0, chr, 1'b0, 3'd0, 32'd0};
    endfunction

    // Expected run typed in, last character in the low byte
    function automatic stim_row_t gold_row(input logic [7:0] chr, input logic [2:0] len,
                                           input logic [31:0] gold);
        return '{ROW_ITEM, '0, '0, chr, 1'b1, len, gold};
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return CH_NL;
        else if (r < 33)
            return CH_TAB;
        else if (r < 78)
            return 8'($urandom_range(8'h7E, 8'h20));
        else if (r < 85)
            return 8'($urandom_range(8'h1F));
        else if (r < 95)
            return 8'($urandom_range(8'hFF, 8'h80));
        else
            return 8'($urandom_range(8'hFF));
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Leaves valid high after the accept; the caller moves on in the same step
    task automatic send_item(input logic [7:0] chr, input logic has_gold,
                             input logic [2:0] gold_len, input logic [31:0] gold);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= chr;
        row_has_gold <= has_gold;
        row_gold_len <= gold_len;
        row_gold     <= gold;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold input until every expected byte is out and the block has gone quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_options(input logic sq, input logic [1:0] mode, input logic tabs,
                               input logic np, input logic ends);
        drain_results();
        write_reg(REG_SQUEEZE, {1'b0, sq});
        write_reg(REG_NUM_MODE, mode);
        write_reg(REG_TABS, {1'b0, tabs});
        write_reg(REG_NONPRINT, {1'b0, np});
        write_reg(REG_ENDS, {1'b0, ends});
    endtask

    // Full two-bit data on every register, so the one-bit ones see the upper bit too
    task automatic random_options();
        drain_results();
        write_reg(REG_SQUEEZE, 2'($urandom_range(3)));
        write_reg(REG_NUM_MODE, 2'($urandom_range(3)));
        write_reg(REG_TABS, 2'($urandom_range(3)));
        write_reg(REG_NONPRINT, 2'($urandom_range(3)));
        write_reg(REG_ENDS, 2'($urandom_range(3)));
        if ($urandom_range(1) == 1)
            write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 2'($urandom_range(3)));
    endtask

    task automatic send_text(input int count);
        for (int n = 0; n < count; n++)
            send_item(pick_text_byte(), 1'b0, 3'd0, 32'd0);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SQUEEZE:  opts.squeeze   = cfg_data[0];
                REG_NUM_MODE: opts.num_mode  = cfg_data;
                REG_TABS:     opts.show_tabs = cfg_data[0];
                REG_NONPRINT: opts.show_np   = cfg_data[0];
                REG_ENDS:     opts.show_ends = cfg_data[0];
                default:      ;
            endcase
        end
    end

    always @(posedge clk)
    begin : take_item
        int len;
        if (rst_n && in_valid && in_ready)
        begin
            items_sent++;
            expand_byte(in_byte);
            if (run_chars.size() == 0)
                squeezed++;
            if (row_has_gold)
            begin
                len = row_gold_len;
                for (int k = 0; k < len; k++)
                    pending_chars.push_back('{row_gold[(len - 1 - k) * 8 +: 8], k == len - 1});
            end
            else
            begin
                len = run_chars.size();
                for (int k = 0; k < len; k++)
                    pending_chars.push_back('{run_chars[k], k == len - 1});
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        out_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pending_chars.size() == 0)
                note_error($sformatf("unexpected output byte %h (last %b), nothing expected",
                                     out_byte, last_of_run));
            else
            begin
                want = pending_chars.pop_front();
                if (out_byte !== want.chr)
                    note_error($sformatf("out_byte expected %h got %h", want.chr, out_byte));
                if (last_of_run !== want.last)
                    note_error($sformatf("last_of_run expected %b got %b",
                                         want.last, last_of_run));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d output bytes still expected", pending_chars.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        // Plain pass-through, then each show option stacked on top
        stim_rows.push_back(gold_row(8'h41, 3'd1, 32'(8'h41)));
        stim_rows.push_back(gold_row(8'h00, 3'd1, 32'(8'h00)));
        stim_rows.push_back(gold_row(8'hFF, 3'd1, 32'(8'hFF)));
        stim_rows.push_back(gold_row(CH_NL, 3'd1, 32'(CH_NL)));
        stim_rows.push_back(reg_row(REG_NONPRINT, 2'd1));
        stim_rows.push_back(gold_row(8'h00, 3'd2, 32'({CH_CARET, CTRL_FLIP})));
        stim_rows.push_back(gold_row(CH_DEL, 3'd2, 32'({CH_CARET, CH_DEL ^ CTRL_FLIP})));
        stim_rows.push_back(gold_row(8'hFF, 3'd4,
                                     {CH_M, CH_DASH, CH_CARET, CH_DEL ^ CTRL_FLIP}));
        stim_rows.push_back(gold_row(8'h80, 3'd4, {CH_M, CH_DASH, CH_CARET, CTRL_FLIP}));
        stim_rows.push_back(gold_row(8'hC1, 3'd3, 32'({CH_M, CH_DASH, 8'h41})));
        stim_rows.push_back(gold_row(CH_TAB, 3'd1, 32'(CH_TAB)));
        stim_rows.push_back(reg_row(REG_TABS, 2'd1));
        stim_rows.push_back(gold_row(CH_TAB, 3'd2, 32'({CH_CARET, CH_I})));
        stim_rows.push_back(reg_row(REG_ENDS, 2'd1));
        stim_rows.push_back(gold_row(CH_NL, 3'd2, 32'({CH_DOLLAR, CH_NL})));
        // Blank run: first empty line kept, the rest dropped
        stim_rows.push_back(reg_row(REG_SQUEEZE, 2'd1));
        stim_rows.push_back(gold_row(CH_NL, 3'd2, 32'({CH_DOLLAR, CH_NL})));
        stim_rows.push_back(gold_row(CH_NL, 3'd0, 32'd0));
        stim_rows.push_back(gold_row(CH_NL, 3'd0, 32'd0));
        stim_rows.push_back(gold_row(8'h78, 3'd1, 32'(8'h78)));
        // Numbering every line, then non-blank only, then the spare mode
        stim_rows.push_back(reg_row(REG_NUM_MODE, MODE_ALL));
        stim_rows.push_back(gold_row(CH_NL, 3'd2, 32'({CH_DOLLAR, CH_NL})));
        stim_rows.push_back(byte_row(8'h42));
        stim_rows.push_back(byte_row(CH_NL));
        stim_rows.push_back(byte_row(CH_NL));
        stim_rows.push_back(reg_row(REG_NUM_MODE, MODE_NONBLANK));
        stim_rows.push_back(byte_row(CH_NL));
        stim_rows.push_back(byte_row(8'h43));
        stim_rows.push_back(byte_row(CH_NL));
        stim_rows.push_back(byte_row(8'h44));
        stim_rows.push_back(reg_row(REG_NUM_MODE, MODE_SPARE));
        stim_rows.push_back(reg_row(REG_SPARE_LO, 2'd3));
        stim_rows.push_back(reg_row(REG_SPARE_HI, 2'd1));
        stim_rows.push_back(byte_row(CH_NL));
        stim_rows.push_back(byte_row(8'h45));
        // Only the low bit of a one-bit register counts
        stim_rows.push_back(reg_row(REG_TABS, 2'd2));
        stim_rows.push_back(gold_row(CH_TAB, 3'd1, 32'(CH_TAB)));
        stim_rows.push_back(reg_row(REG_NONPRINT, 2'd3));
        stim_rows.push_back(reg_row(REG_ENDS, 2'd2));
        stim_rows.push_back(reg_row(REG_SQUEEZE, 2'd2));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(stim_rows[i].idx, stim_rows[i].val);
            end
            else
                send_item(stim_rows[i].chr, stim_rows[i].has_gold,
                          stim_rows[i].gold_len, stim_rows[i].gold);
        end

        // Slow receiver
        set_options(1'b1, MODE_NONBLANK, 1'b1, 1'b1, 1'b1);
        send_text(16);
        random_options();
        send_text(16);

        // Slow sender
        in_idle_pct  = 86;
        out_idle_pct = 28;
        set_options(1'b0, MODE_OFF, 1'b0, 1'b0, 1'b0);
        send_text(16);
        random_options();
        send_text(16);

        // Full rate both ways
        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_options(1'b1, MODE_ALL, 1'b1, 1'b1, 1'b1);
        send_text(16);
        random_options();
        send_text(16);

        drain_results();
        if (pending_chars.size() != 0)
            note_error($sformatf("%0d output bytes never arrived", pending_chars.size()));
        $display("Sent %0d input bytes (%0d squeezed away), checked %0d output bytes",
                 items_sent, squeezed, beats_checked);
        $display("Covered every option register, spare indexes and modes, two idle mixes and full rate");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/tslf_pkg.sv
rtl/tslf_front.sv
rtl/tslf_queue.sv
rtl/tslf_back.sv
rtl/text_stream_line_filter.sv
sim/tb_text_stream_line_filter.sv
